>>> hdl/wgm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Wildcard glob matcher package
// Sizes, pattern constants, item kinds and the control bundle that the top
// level sends to every pattern cell.
// ---------------------------------------------------------------------------
package wgm_pkg;

    // Number of pattern cells (pattern characters that can be stored).
    localparam int PATTERN_MAX = 64;

    // Field widths fixed by the stream format.
    localparam int CHAR_W = 8;
    localparam int POS_W  = 6;
    localparam int CFG_W  = 7;
    localparam int OP_W   = 2;

    // Width that holds any length from zero to PATTERN_MAX.
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    // Width used to compare the written length against PATTERN_MAX.
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    localparam logic [CHAR_W-1:0] GLOB_STAR = 8'h2A;
    localparam logic [CHAR_W-1:0] GLOB_ONE  = 8'h3F;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_SUBJECT = 2'd1,
        OP_END     = 2'd2
    } opcode_t;

    // Shared control for the cell row in one cycle.
    typedef struct packed {
        logic              step;     // advance the active set by one subject byte
        logic              close;    // fold the star closure into the stored set
        logic              restart;  // return to the start position
        logic [CHAR_W-1:0] subject;  // subject byte for a step
    } cell_ctrl_t;

endpackage

>>> hdl/wgm_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Wildcard glob matcher pattern cell
// Holds one pattern character and the active flag of its pattern position,
// passes the star closure and the match to the next position.
// ---------------------------------------------------------------------------
module wgm_cell
    import wgm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load_en,
    input  logic [CHAR_W-1:0] load_char,
    input  cell_ctrl_t        ctrl,
    input  logic              lt_len,       // this position lies inside the pattern
    input  logic              le_len,       // this position is at most the length
    input  logic              restart_bit,  // active value in the start state
    input  logic              carry_in,     // star closure from the left neighbor
    input  logic              match_in,     // byte consumed by the left neighbor
    output logic              carry_out,
    output logic              match_out,
    output logic              closed_out    // live flag after the star closure
);

    logic [CHAR_W-1:0] char_reg;
    logic              active_reg;
    logic              active_next;
    logic              is_star;
    logic              is_one;
    logic              closed;
    logic              next_raw;

    assign is_star = (char_reg == GLOB_STAR);
    assign is_one  = (char_reg == GLOB_ONE);

    // Position is live if it was stored live and lies in range, or a live
    // star just left of it can match an empty run.
    assign closed    = (active_reg & le_len) | carry_in;
    assign carry_out = closed & is_star & lt_len;
    assign match_out = closed & ~is_star & lt_len & (is_one | (char_reg == ctrl.subject));
    assign closed_out = closed;
    // A star keeps its own position live while it swallows the byte.
    assign next_raw  = (closed & is_star & lt_len) | match_in;

    always_comb begin
        active_next = active_reg;
        if (ctrl.restart) begin
            active_next = restart_bit;
        end else if (ctrl.step) begin
            active_next = next_raw;
        end else if (ctrl.close) begin
            active_next = closed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= restart_bit;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            char_reg <= load_char;
        end
    end

endmodule

>>> hdl/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
// Timing: a load or subject transfer takes effect in the cycle it is accepted;
// the verdict of an end transfer is registered at acceptance and is on m_tdata in the next cycle.
// Throughput: one input transfer per cycle unless a verdict waits on a low m_tready;
// the row update is combinational (a star closure chain that ripples once through the row).
// Reset: aresetn (synchronous, active low) clears the length to zero and the
// active set to the start position; stored pattern characters are kept.
// ---------------------------------------------------------------------------
// Wildcard glob matcher
// Matches a streamed subject against a stored pattern with '*' and '?'
// wildcards by tracking the set of live pattern positions in a row of cells.
// ---------------------------------------------------------------------------
module wildcard_glob_matcher
    import wgm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Input stream.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [5:0] position, [13:6] character, [15:14] zero
    input  logic [OP_W-1:0]  s_tuser,   // [1:0] opcode
    // Result stream.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [0] matched, [7:1] zero
    // Pattern length register.
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // -----------------------------------------------------------------------
    // The row holds one cell per pattern position 0 .. PATTERN_MAX-1; the
    // final position (whole pattern consumed) lives here in the top level.
    // After a subject byte the row stores the raw step result and marks it
    // dirty. The star closure is applied on the fly whenever the set is
    // used; before the pattern or length changes, a dirty set is folded once
    // with the closure of the pattern still in force, so later closures see
    // the same set that the pattern at that time would have produced.
    // -----------------------------------------------------------------------

    logic [POS_W-1:0]  in_position;
    logic [CHAR_W-1:0] in_character;
    opcode_t           in_opcode;
    logic              in_xfer;

    logic [CFG_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_eff;
    logic              dirty_reg;
    logic              dirty_next;
    logic              final_reg;
    logic              final_next;
    logic              m_valid_reg;
    logic              matched_reg;

    logic              is_load;
    logic              is_subject;
    logic              is_end;
    cell_ctrl_t        ctrl;

    logic [PATTERN_MAX-1:0] load_en;
    logic [PATTERN_MAX-1:0] lt_len;
    logic [PATTERN_MAX-1:0] le_len;
    logic [PATTERN_MAX-1:0] cell_closed;  // closed live flag of each cell
    logic [PATTERN_MAX:0]   carry;   // carry[p] enters cell p
    logic [PATTERN_MAX:0]   match;   // match[p] enters cell p
    logic                   final_closed;

    assign in_position  = s_tdata[POS_W-1:0];
    assign in_character = s_tdata[POS_W +: CHAR_W];
    assign in_opcode    = opcode_t'(s_tuser);

    // The result register is the only thing that can hold a transfer back.
    assign s_tready = ~m_valid_reg | m_tready;
    assign in_xfer  = s_tvalid & s_tready;

    always_comb begin
        is_load    = 1'b0;
        is_subject = 1'b0;
        is_end     = 1'b0;
        unique case (in_opcode)
            OP_LOAD:    is_load    = 1'b1;
            OP_SUBJECT: is_subject = 1'b1;
            OP_END:     is_end     = 1'b1;
            default:    ;
        endcase
    end

    // Lengths above the row size saturate.
    assign len_eff = (CMP_W'(len_reg) > CMP_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                             : LEN_W'(len_reg);

    assign ctrl.step    = in_xfer & is_subject;
    assign ctrl.restart = in_xfer & is_end;
    assign ctrl.close   = dirty_reg & ((in_xfer & is_load) | cfg_we);
    assign ctrl.subject = in_character;

    assign carry[0] = 1'b0;
    assign match[0] = 1'b0;

    for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_cell
        assign load_en[p] = in_xfer & is_load & (int'(in_position) == p);
        assign lt_len[p]  = (int'(len_eff) > p);
        assign le_len[p]  = (int'(len_eff) >= p);

        wgm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .load_en     (load_en[p]),
            .load_char   (in_character),
            .ctrl        (ctrl),
            .lt_len      (lt_len[p]),
            .le_len      (le_len[p]),
            .restart_bit (p == 0),
            .carry_in    (carry[p]),
            .match_in    (match[p]),
            .carry_out   (carry[p+1]),
            .match_out   (match[p+1]),
            .closed_out  (cell_closed[p])
        );
    end

    // The final position is live once the whole pattern is consumed, either
    // by a byte match or by trailing stars.
    assign final_closed = (final_reg & (int'(len_eff) == PATTERN_MAX)) | carry[PATTERN_MAX];

    always_comb begin
        final_next = final_reg;
        dirty_next = dirty_reg;
        if (ctrl.restart) begin
            final_next = 1'b0;
            dirty_next = 1'b0;
        end else if (ctrl.step) begin
            final_next = match[PATTERN_MAX];
            dirty_next = 1'b1;
        end else if (ctrl.close) begin
            final_next = final_closed;
            dirty_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            final_reg   <= 1'b0;
            dirty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            final_reg <= final_next;
            dirty_reg <= dirty_next;
            if (cfg_we) begin
                len_reg <= cfg_wdata;
            end
            if (ctrl.restart) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The verdict is the closed flag of the position equal to the length.
    always_ff @(posedge aclk) begin
        if (ctrl.restart) begin
            if (int'(len_eff) == PATTERN_MAX) begin
                matched_reg <= final_closed;
            end else begin
                matched_reg <= cell_closed[len_eff[POS_W-1:0]];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, matched_reg};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Wildcard glob matcher testbench
// Loads patterns with '*' and '?' wildcards, streams subjects and end
// transfers, and checks every verdict against a position-set predictor kept
// in step with the transfers that the block accepts. A short directed script
// runs first, then random patterns and subjects under three idling profiles.
// ---------------------------------------------------------------------------
module testbench;
    import wgm_pkg::*;

    // Opcode 3 is not used by the block and must be dropped without a result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CHAR_W-1:0] CH_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B = 8'h62;
    // Spare cycles that drain() waits after the last verdict has come back.
    localparam int DRAIN_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;
    // Active set of the start state: only position 0 is live.
    localparam logic [PATTERN_MAX:0] START_SET = {{PATTERN_MAX{1'b0}}, 1'b1};

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // One line of the directed script. For ROW_CFG the length sits in ch.
    // A pinned row carries its verdict; other end rows use the predictor.
    typedef struct packed {
        row_kind_t         kind;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] ch;
        logic              pinned;
        logic              verdict;
    } script_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;   // [5:0] position, [13:6] character, [15:14] zero
    logic [OP_W-1:0]   s_tuser = '0;   // [1:0] opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;        // [0] matched, [7:1] zero
    logic              cfg_we = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // Verdict override that travels with the item currently offered.
    logic verdict_pinned = 1'b0;
    logic pinned_verdict = 1'b0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int items_sent = 0;
    int failures = 0;

    // Predictor state.
    logic [CHAR_W-1:0]    glob_chars [PATTERN_MAX];
    logic [CFG_W-1:0]     glob_length = '0;
    logic [PATTERN_MAX:0] live = START_SET;
    logic                 expected_verdicts [$];

    // Pattern most recently loaded by the stimulus, used to shape subjects.
    logic [CHAR_W-1:0]    pat_chars [PATTERN_MAX];

    script_row_t script [26] = '{
        // After reset the length is zero: the empty subject matches.
        '{ROW_ITEM, OP_END,     6'd0,  8'h00,     1'b1, 1'b1},
        // Any byte against the empty pattern fails.
        '{ROW_ITEM, OP_SUBJECT, 6'd0,  8'h00,     1'b0, 1'b0},
        '{ROW_ITEM, OP_END,     6'd0,  8'h00,     1'b1, 1'b0},
        '{ROW_ITEM, OP_UNUSED,  6'h3F, 8'hFF,     1'b0, 1'b0},
        // Pattern "?*" followed by a zero byte.
        '{ROW_ITEM, OP_LOAD,    6'd0,  GLOB_ONE,  1'b0, 1'b0},
        '{ROW_ITEM, OP_LOAD,    6'd1,  GLOB_STAR, 1'b0, 1'b0},
        '{ROW_ITEM, OP_LOAD,    6'd2,  8'h00,     1'b0, 1'b0},
        '{ROW_CFG,  OP_LOAD,    6'd0,  8'd3,      1'b0, 1'b0},
        '{ROW_ITEM, OP_SUBJECT, 6'h3F, 8'hFF,     1'b0, 1'b0},
        '{ROW_ITEM, OP_SUBJECT, 6'd0,  8'h41,     1'b0, 1'b0},
        '{ROW_ITEM, OP_SUBJECT, 6'd0,  8'h00,     1'b0, 1'b0},
        '{ROW_ITEM, OP_END,     6'd0,  8'h00,     1'b0, 1'b0},
        '{ROW_ITEM, OP_SUBJECT, 6'd0,  8'h00,     1'b0, 1'b0},
        '{ROW_ITEM, OP_END,     6'd0,  8'h00,     1'b0, 1'b0},
        // The last pattern byte changes while a subject is in progress.
        '{ROW_ITEM, OP_SUBJECT, 6'd0,  CH_B,      1'b0, 1'b0},
        '{ROW_ITEM, OP_LOAD,    6'd2,  CH_B,      1'b0, 1'b0},
        '{ROW_ITEM, OP_SUBJECT, 6'd0,  CH_B,      1'b0, 1'b0},
        '{ROW_ITEM, OP_END,     6'd0,  8'h00,     1'b0, 1'b0},
        // The length shrinks while a subject is in progress.
        '{ROW_ITEM, OP_SUBJECT, 6'd0,  8'h7A,     1'b0, 1'b0},
        '{ROW_CFG,  OP_LOAD,    6'd0,  8'd1,      1'b0, 1'b0},
        '{ROW_ITEM, OP_END,     6'd0,  8'h00,     1'b0, 1'b0},
        // Highest position, then a length above the store size saturates.
        '{ROW_ITEM, OP_LOAD,    6'h3F, 8'hFF,     1'b0, 1'b0},
        '{ROW_CFG,  OP_LOAD,    6'd0,  8'd127,    1'b0, 1'b0},
        '{ROW_ITEM, OP_END,     6'd0,  8'h00,     1'b0, 1'b0},
        '{ROW_CFG,  OP_LOAD,    6'd0,  8'd0,      1'b0, 1'b0},
        '{ROW_ITEM, OP_END,     6'd0,  8'h00,     1'b1, 1'b1}
    };

    wildcard_glob_matcher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    initial begin
        #400000;
        $display("** wildcard_glob_matcher: FAILED **");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic int glob_span();
        return (glob_length > PATTERN_MAX) ? PATTERN_MAX : int'(glob_length);
    endfunction

    // A live star also makes the next position live; positions past the
    // pattern end are dropped.
    function automatic void fold_stars(input int span);
        for (int p = span + 1; p <= PATTERN_MAX; p++) live[p] = 1'b0;
        for (int p = 0; p < span; p++)
            if (live[p] && glob_chars[p] == GLOB_STAR) live[p + 1] = 1'b1;
    endfunction

    function automatic void advance_live(input logic [CHAR_W-1:0] ch);
        int span;
        logic [PATTERN_MAX:0] nxt;
        span = glob_span();
        fold_stars(span);
        nxt = '0;
        for (int p = 0; p < span; p++) begin
            if (live[p]) begin
                if (glob_chars[p] == GLOB_STAR) nxt[p] = 1'b1;
                else if (glob_chars[p] == GLOB_ONE || glob_chars[p] == ch) nxt[p + 1] = 1'b1;
            end
        end
        live = nxt;
        fold_stars(span);
    endfunction

    function automatic logic glob_verdict();
        int span;
        logic v;
        span = glob_span();
        fold_stars(span);
        v = live[span];
        live = START_SET;
        return v;
    endfunction

    task automatic note_failure(input string what, input logic want, input logic got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%0t: %s: expected matched=%b, got %b", $realtime, what, want, got);
    endtask

    // Checks results and tracks accepted transfers in one process, so the
    // order of the two is fixed.
    always @(posedge aclk) begin : track_transfers
        logic want;
        if (!aresetn) begin
            glob_length = '0;
            live = START_SET;
        end else begin
            if (m_tvalid === 1'b1 && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    note_failure("result with no end transfer pending", 1'bx, m_tdata[0]);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[0] !== want) note_failure("matched mismatch", want, m_tdata[0]);
                end
            end
            if (cfg_we) glob_length = cfg_wdata;
            if (s_tvalid && s_tready === 1'b1) begin
                case (s_tuser)
                    OP_LOAD: begin
                        glob_chars[s_tdata[5:0]] = s_tdata[13:6];
                    end
                    OP_SUBJECT: begin
                        advance_live(s_tdata[13:6]);
                    end
                    OP_END: begin
                        want = glob_verdict();
                        expected_verdicts.push_back(verdict_pinned ? pinned_verdict : want);
                    end
                    default: ;
                endcase
            end
        end
    end

    // ---------------- stimulus ----------------

    always @(negedge aclk) m_tready = ($urandom_range(99) >= receiver_stall_pct);

    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [CHAR_W-1:0] ch, input logic pinned,
                             input logic verdict);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {2'b00, ch, pos};
        verdict_pinned = pinned;
        pinned_verdict = verdict;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // Stops offering transfers and waits until every verdict has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_verdicts.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] len);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = len;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pattern_char();
        int r;
        r = $urandom_range(99);
        if (r < 20) return GLOB_STAR;
        if (r < 35) return GLOB_ONE;
        if (r < 60) return CH_A;
        if (r < 80) return CH_B;
        return CHAR_W'($urandom_range(255, 0));
    endfunction

    function automatic logic [CHAR_W-1:0] subject_char();
        int r;
        r = $urandom_range(99);
        if (r < 40) return CH_A;
        if (r < 70) return CH_B;
        return CHAR_W'($urandom_range(255, 0));
    endfunction

    // Builds a subject that fits the pattern, sometimes spoiled by one edit,
    // and streams it with occasional noise in between.
    task automatic run_subject(input int nchars);
        logic [CHAR_W-1:0] subj [$];
        int n;
        int k;
        for (int p = 0; p < nchars; p++) begin
            if (pat_chars[p] == GLOB_STAR) begin
                n = $urandom_range(3, 0);
                repeat (n) subj.push_back(subject_char());
            end else if (pat_chars[p] == GLOB_ONE) begin
                subj.push_back(CHAR_W'($urandom_range(255, 0)));
            end else begin
                subj.push_back(pat_chars[p]);
            end
        end
        if ($urandom_range(99) < 30) begin
            k = $urandom_range(2, 0);
            if (subj.size() == 0 || k == 0) subj.push_back(subject_char());
            else if (k == 1) subj.delete($urandom_range(subj.size() - 1, 0));
            else subj[$urandom_range(subj.size() - 1, 0)] = subject_char();
        end
        foreach (subj[i]) begin
            if ($urandom_range(99) < 3)
                send_item(OP_UNUSED, POS_W'($urandom), CHAR_W'($urandom), 1'b0, 1'b0);
            if ($urandom_range(99) < 2) begin
                k = $urandom_range(PATTERN_MAX - 1, 0);
                pat_chars[k] = pattern_char();
                send_item(OP_LOAD, POS_W'(k), pat_chars[k], 1'b0, 1'b0);
            end
            if ($urandom_range(299) == 0) write_length(CFG_W'($urandom_range(127, 0)));
            send_item(OP_SUBJECT, POS_W'($urandom), subj[i], 1'b0, 1'b0);
        end
        send_item(OP_END, POS_W'($urandom), CHAR_W'($urandom), 1'b0, 1'b0);
    endtask

    // Mostly short patterns; a few full-size ones, a few empty ones and a few oversized lengths.
    task automatic run_pattern();
        int sel;
        int nchars;
        logic [CFG_W-1:0] len;
        sel = $urandom_range(99);
        if (sel < 4) len = CFG_W'(PATTERN_MAX);
        else if (sel < 6) len = CFG_W'($urandom_range(127, PATTERN_MAX + 1));
        else if (sel < 10) len = '0;
        else len = CFG_W'($urandom_range(12, 1));
        nchars = (len > PATTERN_MAX) ? PATTERN_MAX : int'(len);
        for (int p = 0; p < nchars; p++) begin
            pat_chars[p] = pattern_char();
            send_item(OP_LOAD, POS_W'(p), pat_chars[p], 1'b0, 1'b0);
        end
        write_length(len);
        repeat ($urandom_range(4, 1)) run_subject(nchars);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
        int goal;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        goal = items_sent + quota;
        while (items_sent < goal) run_pattern();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        // Every store entry gets written once up front, so no length setting
        // can ever reach an entry that holds no defined character.
        for (int p = 0; p < PATTERN_MAX; p++) send_item(OP_LOAD, POS_W'(p), CH_A, 1'b0, 1'b0);
        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) write_length(script[i].ch[CFG_W-1:0]);
            else send_item(script[i].op, script[i].pos, script[i].ch,
                           script[i].pinned, script[i].verdict);
        end
        run_phase(9, 65, 370);
        run_phase(65, 9, 370);
        run_phase(0, 0, 360);
        drain();
        if (failures == 0 && expected_verdicts.size() == 0)
            $display("** wildcard_glob_matcher: PASSED **");
        else
            $display("** wildcard_glob_matcher: FAILED **");
        $finish;
    end

endmodule

>>> wildcard_glob_matcher.f
hdl/wgm_pkg.sv
hdl/wgm_cell.sv
hdl/wildcard_glob_matcher.sv
bench/testbench.sv
